/* rtl/mjji_pkg.sv */
// ----------------------------------------------------------------------------
// Min-jerk joint interpolator package
// Shared constants, controller commands and status for the interpolator.
// ----------------------------------------------------------------------------
package mjji_pkg;

  localparam int unsigned JOINT_COUNT_DEF = 6;
  localparam int unsigned ANGLE_BITS_DEF  = 16;

  localparam int unsigned STEP_W  = 16;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned BLEND_W = 20;
  localparam int unsigned DIV_CW  = $clog2(FRAC_W);

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(100);
  localparam int unsigned       P_BASE     = 10 * (1 << FRAC_W);
  localparam int unsigned       P_LIN      = 15;
  localparam int unsigned       P_QUAD     = 6;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_A2,
    OP_MUL_A3,
    OP_MUL_S,
    OP_JOINT,
    OP_PUB_MOVE,
    OP_PUB_HOLD
  } mjji_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_A2,
    ST_A3,
    ST_GAIN,
    ST_JOINT,
    ST_PUB_MOVE,
    ST_PUB_HOLD
  } mjji_state_e;

  typedef struct packed {
    logic active;
    logic div_last;
    logic joint_last;
    logic out_free;
  } mjji_status_t;

endpackage

/* rtl/mjji_if.sv */
// ----------------------------------------------------------------------------
// Min-jerk joint interpolator channels
// Request channel (tick or load with goal angles) and result channel.
// ----------------------------------------------------------------------------
interface mjji_req_if #(
  parameter int unsigned JOINT_COUNT = mjji_pkg::JOINT_COUNT_DEF,
  parameter int unsigned ANGLE_BITS  = mjji_pkg::ANGLE_BITS_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic                                   req_type;
  logic [JOINT_COUNT-1:0][ANGLE_BITS-1:0] goal_angle;

  modport source (output valid, req_type, goal_angle, input ready);
  modport sink   (input valid, req_type, goal_angle, output ready);
endinterface

interface mjji_res_if #(
  parameter int unsigned JOINT_COUNT = mjji_pkg::JOINT_COUNT_DEF,
  parameter int unsigned ANGLE_BITS  = mjji_pkg::ANGLE_BITS_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic [JOINT_COUNT-1:0][ANGLE_BITS-1:0] joint_pos;
  logic                                   moving;

  modport source (output valid, joint_pos, moving, input ready);
  modport sink   (input valid, joint_pos, moving, output ready);
endinterface

/* rtl/mjji_ctrl.sv */
// ----------------------------------------------------------------------------
// Min-jerk joint interpolator controller
// Sequences the divide, blend and per-joint update steps of one tick.
// ----------------------------------------------------------------------------
module mjji_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic                   req_type_i,
  output logic                   req_ready_o,
  input  mjji_pkg::mjji_status_t status_i,
  output mjji_pkg::mjji_op_e     cmd_o
);
  import mjji_pkg::*;

  mjji_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = OP_NOP;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_type_i) begin
            cmd_o = OP_LOAD;
          end else if (status_i.active) begin
            cmd_o   = OP_DIV_INIT;
            state_d = ST_DIV;
          end else begin
            state_d = ST_PUB_HOLD;
          end
        end
      end
      ST_DIV: begin
        cmd_o = OP_DIV_STEP;
        if (status_i.div_last) begin
          state_d = ST_A2;
        end
      end
      ST_A2: begin
        cmd_o   = OP_MUL_A2;
        state_d = ST_A3;
      end
      ST_A3: begin
        cmd_o   = OP_MUL_A3;
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o   = OP_MUL_S;
        state_d = ST_JOINT;
      end
      ST_JOINT: begin
        cmd_o = OP_JOINT;
        if (status_i.joint_last) begin
          state_d = ST_PUB_MOVE;
        end
      end
      ST_PUB_MOVE: begin
        if (status_i.out_free) begin
          cmd_o   = OP_PUB_MOVE;
          state_d = ST_IDLE;
        end
      end
      ST_PUB_HOLD: begin
        if (status_i.out_free) begin
          cmd_o   = OP_PUB_HOLD;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/mjji_dp.sv */
// ----------------------------------------------------------------------------
// Min-jerk joint interpolator datapath
// Angle stores, step counters, bit-serial divider, shared multiplier and the
// result register.
// ----------------------------------------------------------------------------
module mjji_dp #(
  parameter int unsigned JOINT_COUNT = mjji_pkg::JOINT_COUNT_DEF,
  parameter int unsigned ANGLE_BITS  = mjji_pkg::ANGLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  mjji_pkg::mjji_op_e                     cmd_i,
  output mjji_pkg::mjji_status_t                 status_o,
  input  logic                                   cfg_we_i,
  input  logic [mjji_pkg::STEP_W-1:0]            cfg_wdata_i,
  input  logic [JOINT_COUNT-1:0][ANGLE_BITS-1:0] goal_angle_i,
  input  logic                                   res_ready_i,
  output logic                                   res_valid_o,
  output logic [JOINT_COUNT-1:0][ANGLE_BITS-1:0] joint_pos_o,
  output logic                                   moving_o
);
  import mjji_pkg::*;

  localparam int unsigned JW  = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int unsigned MBW = (ANGLE_BITS + 1 > BLEND_W + 1) ? ANGLE_BITS + 1 : BLEND_W + 1;
  localparam int unsigned PW  = FRAC_W + 1 + MBW;
  localparam int unsigned SW  = PW - FRAC_W;
  localparam int unsigned PSW = BLEND_W + 1;

  logic [STEP_W-1:0]            interp_steps_q;
  logic signed [ANGLE_BITS-1:0] cur_q   [JOINT_COUNT];
  logic signed [ANGLE_BITS-1:0] start_q [JOINT_COUNT];
  logic signed [ANGLE_BITS-1:0] goal_q  [JOINT_COUNT];
  logic [STEP_W-1:0]            step_cnt_q;
  logic [STEP_W-1:0]            step_tot_q;

  logic [STEP_W-1:0]  rem_q, rem_d;
  logic [FRAC_W-1:0]  alpha_q;
  logic [DIV_CW-1:0]  div_cnt_q;
  logic [STEP_W:0]    rem_sh;
  logic               rem_ge;

  logic [FRAC_W-1:0]  a2_q;
  logic [FRAC_W-1:0]  a3_q;
  logic [BLEND_W-1:0] p_q;
  logic [PSW-1:0]     p_sum;
  logic [FRAC_W-1:0]  s_q;
  logic [JW-1:0]      jidx_q;

  logic signed [FRAC_W:0]       mul_a;
  logic signed [MBW-1:0]        mul_b;
  logic signed [PW-1:0]         prod;
  logic signed [ANGLE_BITS-1:0] start_sel;
  logic signed [ANGLE_BITS-1:0] goal_sel;
  logic signed [ANGLE_BITS:0]   diff;
  logic signed [SW-1:0]         prod_sh;
  logic signed [SW-1:0]         pos_sum;

  logic                                   out_valid_q;
  logic [JOINT_COUNT-1:0][ANGLE_BITS-1:0] out_pos_q;
  logic                                   out_moving_q;

  // Restoring division of step_count * 2^16 by step_total, one quotient bit a cycle.
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, step_tot_q};
  always_comb begin
    if (rem_ge) begin
      rem_d = STEP_W'(rem_sh - {1'b0, step_tot_q});
    end else begin
      rem_d = rem_sh[STEP_W-1:0];
    end
  end

  assign p_sum = PSW'(P_BASE) + PSW'(a2_q) * PSW'(P_QUAD) - PSW'(alpha_q) * PSW'(P_LIN);

  assign start_sel = start_q[jidx_q];
  assign goal_sel  = goal_q[jidx_q];
  assign diff      = (ANGLE_BITS + 1)'(goal_sel) - (ANGLE_BITS + 1)'(start_sel);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i)
      OP_MUL_A2: begin
        mul_a = (FRAC_W + 1)'(alpha_q);
        mul_b = MBW'(alpha_q);
      end
      OP_MUL_A3: begin
        mul_a = (FRAC_W + 1)'(a2_q);
        mul_b = MBW'(alpha_q);
      end
      OP_MUL_S: begin
        mul_a = (FRAC_W + 1)'(a3_q);
        mul_b = MBW'(p_q);
      end
      OP_JOINT: begin
        mul_a = (FRAC_W + 1)'(s_q);
        mul_b = MBW'(diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_sh = prod[PW-1:FRAC_W];
  assign pos_sum = prod_sh + SW'(start_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interp_steps_q <= STEP_RESET;
      step_cnt_q     <= '0;
      step_tot_q     <= STEP_W'(1);
      out_valid_q    <= 1'b0;
      for (int j = 0; j < JOINT_COUNT; j++) begin
        cur_q[j]   <= '0;
        start_q[j] <= '0;
        goal_q[j]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        interp_steps_q <= cfg_wdata_i;
      end
      if (cmd_i == OP_LOAD) begin
        for (int j = 0; j < JOINT_COUNT; j++) begin
          goal_q[j]  <= goal_angle_i[j];
          start_q[j] <= cur_q[j];
        end
        step_cnt_q <= '0;
        step_tot_q <= (interp_steps_q == '0) ? STEP_W'(1) : interp_steps_q;
      end
      if (cmd_i == OP_JOINT) begin
        cur_q[jidx_q] <= pos_sum[ANGLE_BITS-1:0];
      end
      if (cmd_i == OP_PUB_MOVE) begin
        step_cnt_q <= step_cnt_q + STEP_W'(1);
      end
      if (cmd_i == OP_PUB_MOVE || cmd_i == OP_PUB_HOLD) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i) inside
      OP_DIV_INIT: begin
        rem_q     <= step_cnt_q;
        div_cnt_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q     <= rem_d;
        alpha_q   <= {alpha_q[FRAC_W-2:0], rem_ge};
        div_cnt_q <= div_cnt_q + DIV_CW'(1);
      end
      OP_MUL_A2: begin
        a2_q <= prod[2*FRAC_W-1:FRAC_W];
      end
      OP_MUL_A3: begin
        a3_q <= prod[2*FRAC_W-1:FRAC_W];
        p_q  <= p_sum[BLEND_W-1:0];
      end
      OP_MUL_S: begin
        if (|prod[PW-1:2*FRAC_W]) begin
          s_q <= '1;
        end else begin
          s_q <= prod[2*FRAC_W-1:FRAC_W];
        end
        jidx_q <= '0;
      end
      OP_JOINT: begin
        jidx_q <= jidx_q + JW'(1);
      end
      OP_PUB_MOVE, OP_PUB_HOLD: begin
        for (int j = 0; j < JOINT_COUNT; j++) begin
          out_pos_q[j] <= cur_q[j];
        end
        out_moving_q <= (cmd_i == OP_PUB_MOVE);
      end
      default: begin
      end
    endcase
  end

  assign status_o.active     = step_cnt_q < step_tot_q;
  assign status_o.div_last   = div_cnt_q == DIV_CW'(FRAC_W - 1);
  assign status_o.joint_last = jidx_q == JW'(JOINT_COUNT - 1);
  assign status_o.out_free   = !out_valid_q || res_ready_i;

  assign res_valid_o = out_valid_q;
  assign joint_pos_o = out_pos_q;
  assign moving_o    = out_moving_q;

endmodule

/* rtl/min_jerk_joint_interpolator_core.sv */
// ----------------------------------------------------------------------------
// Min-jerk joint interpolator
// Quintic minimum-jerk blend from latched start angles to goal angles for a
// set of joints, advanced by one step on each tick transaction.
// ----------------------------------------------------------------------------
//  Channel  Dir  Transaction       Payload
//  req_i    in   valid & ready     req_type, goal_angle[JOINT_COUNT]
//  res_o    out  valid & ready     joint_pos[JOINT_COUNT], moving
//  cfg      in   cfg_we_i          cfg_wdata_i (steps per move)
//
// A load gives no result. A moving tick runs the bit-serial divider, then the
// shared multiplier once per blend term and once per joint, then publishes.
// A tick after the move has ended publishes the current angles as not moving.
// The result register lets a new request be taken while a result waits; a
// stalled result holds the block only when the next result is ready. Reset
// clears all angles and the step count, not the divider or joint counters.
// ----------------------------------------------------------------------------
module min_jerk_joint_interpolator_core #(
  parameter int unsigned JOINT_COUNT = mjji_pkg::JOINT_COUNT_DEF,
  parameter int unsigned ANGLE_BITS  = mjji_pkg::ANGLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mjji_req_if.sink                    req_i,
  mjji_res_if.source                  res_o,
  input  logic                        cfg_we_i,
  input  logic [mjji_pkg::STEP_W-1:0] cfg_wdata_i
);
  import mjji_pkg::*;

  mjji_op_e     cmd;
  mjji_status_t status;

  mjji_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mjji_dp #(
    .JOINT_COUNT (JOINT_COUNT),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .goal_angle_i (req_i.goal_angle),
    .res_ready_i  (res_o.ready),
    .res_valid_o  (res_o.valid),
    .joint_pos_o  (res_o.joint_pos),
    .moving_o     (res_o.moving)
  );

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.req_type) |=> !$rose(res_o.valid))
    else $error("A load transaction produced a result.");

  a_result_from_publish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(cmd == OP_PUB_MOVE || cmd == OP_PUB_HOLD))
    else $error("Result appeared without a publish command.");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == OP_DIV_STEP || cmd == OP_JOINT) |-> !req_i.ready)
    else $error("Request accepted while a tick is in progress.");

  a_moving_after_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == OP_PUB_MOVE) |=> (res_o.valid && res_o.moving))
    else $error("Moving result not presented after an interpolation step.");

endmodule
